// ----- rtl/signal_match_queue_macros.svh -----
// Assertion macros used by the signal match queue RTL.
`ifndef SIGNAL_MATCH_QUEUE_MACROS_SVH
`define SIGNAL_MATCH_QUEUE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SMQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SMQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/smq_pkg.sv -----
// Package with the widths, status codes, command codes and cell control type of the signal match queue.
`timescale 1ns / 1ps

package smq_pkg;

  localparam int ID_W  = 32;
  localparam int SIG_W = 8;
  localparam int ST_W  = 2;

  typedef enum logic [ST_W-1:0] {
    ST_APPENDED = 2'd0,
    ST_TAKEN    = 2'd1,
    ST_NOMATCH  = 2'd2,
    ST_DROPPED  = 2'd3
  } status_t;

  typedef enum logic {
    CMD_APPEND = 1'b0,
    CMD_TAKE   = 1'b1
  } cmd_t;

  // Per-cell control: a write takes the broadcast pair, a shift takes the right neighbor.
  typedef struct packed {
    logic wr;
    logic shift;
  } cell_ctl_t;

endpackage

// ----- rtl/smq_cell.sv -----
// One queue cell holding a (task id, signal) pair that shifts toward the head.
`timescale 1ns / 1ps

module smq_cell (
  input  logic                     clk,
  input  smq_pkg::cell_ctl_t       ctl,
  input  logic [smq_pkg::ID_W-1:0] wr_id,
  input  logic [smq_pkg::SIG_W-1:0] wr_sig,
  input  logic [smq_pkg::ID_W-1:0] nbr_id,
  input  logic [smq_pkg::SIG_W-1:0] nbr_sig,
  output logic [smq_pkg::ID_W-1:0] id,
  output logic [smq_pkg::SIG_W-1:0] sig
);

  // A write to the tail has priority over the shift from the neighbor.
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      id  <= wr_id;
      sig <= wr_sig;
    end else if (ctl.shift) begin
      id  <= nbr_id;
      sig <= nbr_sig;
    end
  end

endmodule

// ----- rtl/signal_match_queue.sv -----
// Ordered (task id, signal) queue with oldest-first keyed removal, built as a chain of cells.
// Timing: an append, or a take on an empty queue, goes from idle to the finish state and
// then loads the output register; any other take scans first, the whole queue rotating once
// through the head cell, one entry per cycle, and only the head is compared.
// Throughput: one transaction in work at a time; the next can be accepted once the result
// reaches the output register, later while a finished result waits for that register.
// Reset clears the fill count, state, step count, found flag and m_tvalid, not the slots.
`timescale 1ns / 1ps
`include "signal_match_queue_macros.svh"

module signal_match_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // task_id [31:0], sig_num [39:32]
  input  logic [1:0]  s_tuser,   // cmd [0], match_any [1]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // found_id [31:0], found_sig [39:32]
  output logic [1:0]  m_tuser    // status [1:0]
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t                     state;
  logic [CNT_W-1:0]           cnt;
  logic [CNT_W-1:0]           steps;
  logic                       found;
  logic                       any_r;
  logic [smq_pkg::SIG_W-1:0]  key_r;
  smq_pkg::status_t           res_st;
  logic [smq_pkg::ID_W-1:0]   res_id;
  logic [smq_pkg::SIG_W-1:0]  res_sig;

  logic [smq_pkg::ID_W-1:0]   cell_id  [QUEUE_DEPTH];
  logic [smq_pkg::SIG_W-1:0]  cell_sig [QUEUE_DEPTH];

  logic                       accept;
  logic                       is_append;
  logic                       full;
  logic                       scan_step;
  logic                       head_hit;
  logic                       remove;
  logic                       wr_any;
  logic [CNT_W-1:0]           cnt_dec;
  logic [IDX_W-1:0]           wr_idx;
  logic [smq_pkg::ID_W-1:0]   wr_id;
  logic [smq_pkg::SIG_W-1:0]  wr_sig;
  logic                       out_free;

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign is_append = (s_tuser[0] == smq_pkg::CMD_APPEND);
  assign full      = (cnt == CNT_W'(QUEUE_DEPTH));
  assign out_free  = !m_tvalid || m_tready;

  // During a take the head leaves every cycle; unless it is the entry being removed,
  // it goes back in at the tail, so once every entry has passed the head the order is restored.
  assign scan_step = (state == S_SCAN);
  assign head_hit  = any_r || (cell_sig[0] == key_r);
  assign remove    = scan_step && !found && head_hit;
  assign cnt_dec   = cnt - CNT_W'(1);
  assign wr_any    = (accept && is_append && !full) || (scan_step && !remove);
  assign wr_idx    = accept ? cnt[IDX_W-1:0] : cnt_dec[IDX_W-1:0];
  assign wr_id     = accept ? s_tdata[31:0] : cell_id[0];
  assign wr_sig    = accept ? s_tdata[39:32] : cell_sig[0];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    smq_pkg::cell_ctl_t        ctl;
    logic [smq_pkg::ID_W-1:0]  nbr_id;
    logic [smq_pkg::SIG_W-1:0] nbr_sig;

    assign ctl.wr    = wr_any && (wr_idx == IDX_W'(i));
    assign ctl.shift = scan_step;

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nbr_id  = '0;
      assign nbr_sig = '0;
    end else begin : g_mid
      assign nbr_id  = cell_id[i+1];
      assign nbr_sig = cell_sig[i+1];
    end

    smq_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .wr_id   (wr_id),
      .wr_sig  (wr_sig),
      .nbr_id  (nbr_id),
      .nbr_sig (nbr_sig),
      .id      (cell_id[i]),
      .sig     (cell_sig[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      steps    <= '0;
      found    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // A new result may replace the one leaving in the same cycle.
      if (state == S_FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            any_r   <= s_tuser[1];
            key_r   <= s_tdata[39:32];
            res_id  <= '0;
            res_sig <= '0;
            found   <= 1'b0;
            steps   <= cnt;
            if (is_append) begin
              if (full) begin
                res_st <= smq_pkg::ST_DROPPED;
              end else begin
                res_st <= smq_pkg::ST_APPENDED;
                cnt    <= cnt + CNT_W'(1);
              end
              state <= S_FINISH;
            end else if (cnt == '0) begin
              res_st <= smq_pkg::ST_NOMATCH;
              state  <= S_FINISH;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (remove) begin
            found   <= 1'b1;
            res_id  <= cell_id[0];
            res_sig <= cell_sig[0];
            cnt     <= cnt_dec;
          end
          steps <= steps - CNT_W'(1);
          if (steps == CNT_W'(1)) begin
            res_st <= (found || remove) ? smq_pkg::ST_TAKEN : smq_pkg::ST_NOMATCH;
            state  <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            m_tuser  <= res_st;
            m_tdata  <= {res_sig, res_id};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SMQ_ASSERT_SAME(a_cnt_bound, 1'b1, cnt <= CNT_W'(QUEUE_DEPTH), "fill count above depth")
  `SMQ_ASSERT_NEXT(a_append_grows, accept && is_append && !full, cnt == $past(cnt) + CNT_W'(1), "append did not grow the queue")
  `SMQ_ASSERT_SAME(a_scan_steps, state == S_SCAN, steps != '0 && cnt != '0, "scan running with no entries left")
  `SMQ_ASSERT_SAME(a_zero_payload, m_tvalid && m_tuser != smq_pkg::ST_TAKEN, m_tdata == '0, "payload set without a removed entry")

endmodule
